@@ rtl/bbrt_pkg.sv @@
// ---------------------------------------------------------------------------
// bbrt_pkg: shared constants for the bounding-box triangle raster unit
// Command codes, configuration register indexes and register widths.
// ---------------------------------------------------------------------------
package bbrt_pkg;

  // Configuration register data width and index width
  localparam int CFG_BITS     = 13;
  localparam int CFG_IDX_BITS = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Image dimension after reset
  localparam logic [CFG_BITS-1:0] DIM_RESET = 13'd4096;

  // Input item command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

endpackage

@@ rtl/bbrt_scan.sv @@
// ---------------------------------------------------------------------------
// bbrt_scan: triangle setup and bounding-box scan sequencer
// Holds the image size registers, clamps the box on a load, keeps the scan
// position and issues one pixel per active step item into the first pipeline stage.
// ---------------------------------------------------------------------------
module bbrt_scan #(
  parameter int COORD_BITS = 16,
  parameter int MAX_DIM    = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [bbrt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [bbrt_pkg::CFG_BITS-1:0]        cfg_wdata,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic signed [COORD_BITS-1:0]         in_v0_x,
  input  logic signed [COORD_BITS-1:0]         in_v0_y,
  input  logic signed [COORD_BITS-1:0]         in_v1_x,
  input  logic signed [COORD_BITS-1:0]         in_v1_y,
  input  logic signed [COORD_BITS-1:0]         in_v2_x,
  input  logic signed [COORD_BITS-1:0]         in_v2_y,
  // stage 1 pixel
  output logic                                 s1_valid,
  input  logic                                 s1_ready,
  output logic [$clog2(MAX_DIM)-1:0]           s1_px,
  output logic [$clog2(MAX_DIM)-1:0]           s1_py,
  output logic                                 s1_last,
  output logic signed [((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                        COORD_BITS : $clog2(MAX_DIM) + 1):0] s1_pax,
  output logic signed [((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                        COORD_BITS : $clog2(MAX_DIM) + 1):0] s1_pay,
  output logic signed [COORD_BITS:0]           s1_ax,
  output logic signed [COORD_BITS:0]           s1_ay,
  output logic signed [COORD_BITS:0]           s1_cx,
  output logic signed [COORD_BITS:0]           s1_cy,
  output logic signed [2*COORD_BITS+1:0]       s1_area_p0,
  output logic signed [2*COORD_BITS+1:0]       s1_area_p1
);

  localparam int DIM_BITS = $clog2(MAX_DIM);
  localparam int DW       = COORD_BITS + 1;
  localparam int LW       = (COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1;
  localparam int PAW      = LW + 1;
  localparam int AW       = 2 * DW;
  localparam int EXW      = (bbrt_pkg::CFG_BITS > DIM_BITS + 1) ?
                            bbrt_pkg::CFG_BITS : DIM_BITS + 1;

  // configuration registers
  logic [bbrt_pkg::CFG_BITS-1:0] width_r, height_r;

  // triangle state
  logic signed [COORD_BITS-1:0] v0x_r, v0y_r;
  logic signed [DW-1:0]         ax_r, ay_r, cx_r, cy_r;
  logic signed [AW-1:0]         area_p0_r, area_p1_r;
  logic [DIM_BITS-1:0]          lo_x_r, lo_y_r, hi_x_r, hi_y_r;

  // scan state
  logic                active_r, active_nxt;
  logic [DIM_BITS-1:0] sx_r, sx_nxt, sy_r, sy_nxt;

  // stage 1 valid
  logic s1_valid_r;

  // clamp datapath
  logic [EXW-1:0]       w_ext, h_ext, eff_w, eff_h;
  logic signed [LW-1:0] lim_x, lim_y;
  logic signed [LW-1:0] c0x, c0y, c1x, c1y, c2x, c2y;
  logic signed [LW-1:0] mn_x, mn_y, mx_x, mx_y;
  logic signed [LW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic                 box_ok;
  logic signed [DW-1:0] ld_ax, ld_ay, ld_cx, ld_cy;

  logic in_fire, is_load, is_step, last_hit;
  logic signed [PAW-1:0] pax, pay;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bbrt_pkg::DIM_RESET;
      height_r <= bbrt_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbrt_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        bbrt_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective image size and clamp limits (size - 1, may be -1)
  assign w_ext = EXW'(width_r);
  assign h_ext = EXW'(height_r);
  assign eff_w = (w_ext > EXW'(MAX_DIM)) ? EXW'(MAX_DIM) : w_ext;
  assign eff_h = (h_ext > EXW'(MAX_DIM)) ? EXW'(MAX_DIM) : h_ext;
  assign lim_x = $signed(LW'(eff_w)) - $signed(LW'(1));
  assign lim_y = $signed(LW'(eff_h)) - $signed(LW'(1));

  assign c0x = LW'(in_v0_x);
  assign c0y = LW'(in_v0_y);
  assign c1x = LW'(in_v1_x);
  assign c1y = LW'(in_v1_y);
  assign c2x = LW'(in_v2_x);
  assign c2y = LW'(in_v2_y);

  // bounding box clamped to the image
  always_comb begin
    mn_x = (c0x < c1x) ? c0x : c1x;
    mn_x = (c2x < mn_x) ? c2x : mn_x;
    mx_x = (c0x > c1x) ? c0x : c1x;
    mx_x = (c2x > mx_x) ? c2x : mx_x;
    mn_y = (c0y < c1y) ? c0y : c1y;
    mn_y = (c2y < mn_y) ? c2y : mn_y;
    mx_y = (c0y > c1y) ? c0y : c1y;
    mx_y = (c2y > mx_y) ? c2y : mx_y;

    lo_x = (mn_x < lim_x) ? mn_x : lim_x;
    lo_x = lo_x[LW-1] ? '0 : lo_x;
    lo_y = (mn_y < lim_y) ? mn_y : lim_y;
    lo_y = lo_y[LW-1] ? '0 : lo_y;
    hi_x = mx_x[LW-1] ? '0 : mx_x;
    hi_x = (hi_x < lim_x) ? hi_x : lim_x;
    hi_y = mx_y[LW-1] ? '0 : mx_y;
    hi_y = (hi_y < lim_y) ? hi_y : lim_y;

    box_ok = (lo_x <= hi_x) && (lo_y <= hi_y);
  end

  // edge vectors from v0
  assign ld_ax = DW'(in_v1_x) - DW'(in_v0_x);
  assign ld_ay = DW'(in_v1_y) - DW'(in_v0_y);
  assign ld_cx = DW'(in_v2_x) - DW'(in_v0_x);
  assign ld_cy = DW'(in_v2_y) - DW'(in_v0_y);

  // handshake and command decode
  assign in_ready = !s1_valid_r || s1_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_load  = in_fire && (in_command == bbrt_pkg::CMD_LOAD);
  assign is_step  = in_fire && (in_command == bbrt_pkg::CMD_STEP) && active_r;
  assign last_hit = (sx_r == hi_x_r) && (sy_r == hi_y_r);

  // scan position: y inner, x outer
  always_comb begin
    active_nxt = active_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    priority if (is_load) begin
      active_nxt = box_ok;
      sx_nxt     = lo_x[DIM_BITS-1:0];
      sy_nxt     = lo_y[DIM_BITS-1:0];
    end else if (is_step) begin
      priority if (last_hit) begin
        active_nxt = 1'b0;
      end else if (sy_r >= hi_y_r) begin
        sy_nxt = lo_y_r;
        sx_nxt = sx_r + DIM_BITS'(1);
      end else begin
        sy_nxt = sy_r + DIM_BITS'(1);
      end
    end else begin
      active_nxt = active_r;
    end
  end

  // offsets of v0 from the pixel (v0 - pixel)
  assign pax = PAW'(v0x_r) - $signed(PAW'(sx_r));
  assign pay = PAW'(v0y_r) - $signed(PAW'(sy_r));

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (in_ready) begin
        s1_valid_r <= is_step;
      end
    end
  end

  // triangle setup and scan position
  always_ff @(posedge clk) begin
    sx_r <= sx_nxt;
    sy_r <= sy_nxt;
    if (is_load) begin
      v0x_r     <= in_v0_x;
      v0y_r     <= in_v0_y;
      ax_r      <= ld_ax;
      ay_r      <= ld_ay;
      cx_r      <= ld_cx;
      cy_r      <= ld_cy;
      area_p0_r <= AW'(ld_ax) * AW'(ld_cy);
      area_p1_r <= AW'(ld_cx) * AW'(ld_ay);
      lo_x_r    <= lo_x[DIM_BITS-1:0];
      lo_y_r    <= lo_y[DIM_BITS-1:0];
      hi_x_r    <= hi_x[DIM_BITS-1:0];
      hi_y_r    <= hi_y[DIM_BITS-1:0];
    end
  end

  // stage 1 pixel payload
  always_ff @(posedge clk) begin
    if (is_step) begin
      s1_px      <= sx_r;
      s1_py      <= sy_r;
      s1_last    <= last_hit;
      s1_pax     <= pax;
      s1_pay     <= pay;
      s1_ax      <= ax_r;
      s1_ay      <= ay_r;
      s1_cx      <= cx_r;
      s1_cy      <= cy_r;
      s1_area_p0 <= area_p0_r;
      s1_area_p1 <= area_p1_r;
    end
  end

  assign s1_valid = s1_valid_r;

endmodule

@@ rtl/bbrt_edge_mul.sv @@
// ---------------------------------------------------------------------------
// bbrt_edge_mul: edge function product stage
// Forms the four cross products of the two barycentric edge functions and
// the doubled triangle area, one pixel per cycle when not stalled by stage 2.
// ---------------------------------------------------------------------------
module bbrt_edge_mul #(
  parameter int COORD_BITS = 16,
  parameter int MAX_DIM    = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // stage 1 pixel
  input  logic                                 s1_valid,
  output logic                                 s1_ready,
  input  logic [$clog2(MAX_DIM)-1:0]           s1_px,
  input  logic [$clog2(MAX_DIM)-1:0]           s1_py,
  input  logic                                 s1_last,
  input  logic signed [((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                       COORD_BITS : $clog2(MAX_DIM) + 1):0] s1_pax,
  input  logic signed [((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                       COORD_BITS : $clog2(MAX_DIM) + 1):0] s1_pay,
  input  logic signed [COORD_BITS:0]           s1_ax,
  input  logic signed [COORD_BITS:0]           s1_ay,
  input  logic signed [COORD_BITS:0]           s1_cx,
  input  logic signed [COORD_BITS:0]           s1_cy,
  input  logic signed [2*COORD_BITS+1:0]       s1_area_p0,
  input  logic signed [2*COORD_BITS+1:0]       s1_area_p1,
  // stage 2 products
  output logic                                 s2_valid,
  input  logic                                 s2_ready,
  output logic [$clog2(MAX_DIM)-1:0]           s2_px,
  output logic [$clog2(MAX_DIM)-1:0]           s2_py,
  output logic                                 s2_last,
  output logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                       COORD_BITS : $clog2(MAX_DIM) + 1) + 1:0] s2_m0,
  output logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                       COORD_BITS : $clog2(MAX_DIM) + 1) + 1:0] s2_m1,
  output logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                       COORD_BITS : $clog2(MAX_DIM) + 1) + 1:0] s2_m2,
  output logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                       COORD_BITS : $clog2(MAX_DIM) + 1) + 1:0] s2_m3,
  output logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                       COORD_BITS : $clog2(MAX_DIM) + 1) + 3:0] s2_area
);

  localparam int DIM_BITS = $clog2(MAX_DIM);
  localparam int DW       = COORD_BITS + 1;
  localparam int PAW      = ((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1;
  localparam int PRW      = DW + PAW;
  localparam int EW       = PRW + 2;

  logic s2_valid_r;

  assign s1_ready = !s2_valid_r || s2_ready;

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  // u = cx*pay - pax*cy, v = pax*ay - ax*pay; area = ax*cy - cx*ay
  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_last <= s1_last;
      s2_m0   <= PRW'(s1_cx) * PRW'(s1_pay);
      s2_m1   <= PRW'(s1_pax) * PRW'(s1_cy);
      s2_m2   <= PRW'(s1_pax) * PRW'(s1_ay);
      s2_m3   <= PRW'(s1_ax) * PRW'(s1_pay);
      s2_area <= EW'(s1_area_p0) - EW'(s1_area_p1);
    end
  end

  assign s2_valid = s2_valid_r;

endmodule

@@ rtl/bbrt_cover.sv @@
// ---------------------------------------------------------------------------
// bbrt_cover: coverage test and result register
// Combines the edge products into u and v, applies the inclusive sign test
// against the doubled area and holds the result item for the output channel.
// ---------------------------------------------------------------------------
module bbrt_cover #(
  parameter int COORD_BITS = 16,
  parameter int MAX_DIM    = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // stage 2 products
  input  logic                                 s2_valid,
  output logic                                 s2_ready,
  input  logic [$clog2(MAX_DIM)-1:0]           s2_px,
  input  logic [$clog2(MAX_DIM)-1:0]           s2_py,
  input  logic                                 s2_last,
  input  logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                      COORD_BITS : $clog2(MAX_DIM) + 1) + 1:0] s2_m0,
  input  logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                      COORD_BITS : $clog2(MAX_DIM) + 1) + 1:0] s2_m1,
  input  logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                      COORD_BITS : $clog2(MAX_DIM) + 1) + 1:0] s2_m2,
  input  logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                      COORD_BITS : $clog2(MAX_DIM) + 1) + 1:0] s2_m3,
  input  logic signed [COORD_BITS + ((COORD_BITS > $clog2(MAX_DIM) + 1) ?
                      COORD_BITS : $clog2(MAX_DIM) + 1) + 3:0] s2_area,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [$clog2(MAX_DIM)-1:0]           out_pixel_x,
  output logic [$clog2(MAX_DIM)-1:0]           out_pixel_y,
  output logic                                 out_covered,
  output logic                                 out_last_pixel
);

  localparam int DIM_BITS = $clog2(MAX_DIM);
  localparam int PAW      = ((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1;
  localparam int EW       = COORD_BITS + 1 + PAW + 2;

  logic                 out_valid_r;
  logic signed [EW-1:0] u, v, uv;
  logic                 hit;

  assign s2_ready = !out_valid_r || out_ready;

  // edge functions and inclusive sign test; zero area covers nothing
  assign u  = EW'(s2_m0) - EW'(s2_m1);
  assign v  = EW'(s2_m2) - EW'(s2_m3);
  assign uv = u + v;

  always_comb begin
    priority if (s2_area == '0) begin
      hit = 1'b0;
    end else if (!s2_area[EW-1]) begin
      hit = !u[EW-1] && !v[EW-1] && (uv <= s2_area);
    end else begin
      hit = (u[EW-1] || (u == '0)) && (v[EW-1] || (v == '0)) && (uv >= s2_area);
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      out_pixel_x    <= s2_px;
      out_pixel_y    <= s2_py;
      out_covered    <= hit;
      out_last_pixel <= s2_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/bbox_barycentric_triangle_raster_unit.sv @@
// ---------------------------------------------------------------------------
// bbox_barycentric_triangle_raster_unit: bounding-box triangle rasterizer
// Loads a triangle, clamps its bounding box to the image and walks the box
// (x outer, y inner), flagging each pixel covered by an exact edge test.
//
//   Channel  Ports                          Moves
//   -------  -----------------------------  --------------------------------
//   cfg      cfg_we, cfg_index, cfg_wdata   write of image width / height
//   in       in_valid/in_ready + fields     load (three vertices) or step
//   out      out_valid/out_ready + fields   one box pixel per active step
//
// Loads and steps can arrive back to back while in_ready is high.
// A step's pixel enters the scan stage register at the accepting edge, then
// passes the product stage register to the output register of the coverage
// stage; throughput is one item/cycle when the output is not stalled.
// Reset sets both image dimensions to 4096, ends any scan and empties the
// pipeline. A stalled output holds the pipe; input stalls once all three
// stages hold a pixel. Loads and idle steps produce no result.
// ---------------------------------------------------------------------------
module bbox_barycentric_triangle_raster_unit #(
  parameter int COORD_BITS = 16,
  parameter int MAX_DIM    = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [bbrt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [bbrt_pkg::CFG_BITS-1:0]        cfg_wdata,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic signed [COORD_BITS-1:0]         in_v0_x,
  input  logic signed [COORD_BITS-1:0]         in_v0_y,
  input  logic signed [COORD_BITS-1:0]         in_v1_x,
  input  logic signed [COORD_BITS-1:0]         in_v1_y,
  input  logic signed [COORD_BITS-1:0]         in_v2_x,
  input  logic signed [COORD_BITS-1:0]         in_v2_y,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [$clog2(MAX_DIM)-1:0]           out_pixel_x,
  output logic [$clog2(MAX_DIM)-1:0]           out_pixel_y,
  output logic                                 out_covered,
  output logic                                 out_last_pixel
);

  localparam int DIM_BITS = $clog2(MAX_DIM);
  localparam int DW       = COORD_BITS + 1;
  localparam int PAW      = ((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 1;
  localparam int AW       = 2 * DW;
  localparam int PRW      = DW + PAW;
  localparam int EW       = PRW + 2;

  // scan stage to product stage
  logic                  s1_valid, s1_ready, s1_last;
  logic [DIM_BITS-1:0]   s1_px, s1_py;
  logic signed [PAW-1:0] s1_pax, s1_pay;
  logic signed [DW-1:0]  s1_ax, s1_ay, s1_cx, s1_cy;
  logic signed [AW-1:0]  s1_area_p0, s1_area_p1;

  // product stage to coverage stage
  logic                  s2_valid, s2_ready, s2_last;
  logic [DIM_BITS-1:0]   s2_px, s2_py;
  logic signed [PRW-1:0] s2_m0, s2_m1, s2_m2, s2_m3;
  logic signed [EW-1:0]  s2_area;

  // setup and scan
  bbrt_scan #(
    .COORD_BITS (COORD_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_v0_x    (in_v0_x),
    .in_v0_y    (in_v0_y),
    .in_v1_x    (in_v1_x),
    .in_v1_y    (in_v1_y),
    .in_v2_x    (in_v2_x),
    .in_v2_y    (in_v2_y),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_px      (s1_px),
    .s1_py      (s1_py),
    .s1_last    (s1_last),
    .s1_pax     (s1_pax),
    .s1_pay     (s1_pay),
    .s1_ax      (s1_ax),
    .s1_ay      (s1_ay),
    .s1_cx      (s1_cx),
    .s1_cy      (s1_cy),
    .s1_area_p0 (s1_area_p0),
    .s1_area_p1 (s1_area_p1)
  );

  // edge products
  bbrt_edge_mul #(
    .COORD_BITS (COORD_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_edge_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_px      (s1_px),
    .s1_py      (s1_py),
    .s1_last    (s1_last),
    .s1_pax     (s1_pax),
    .s1_pay     (s1_pay),
    .s1_ax      (s1_ax),
    .s1_ay      (s1_ay),
    .s1_cx      (s1_cx),
    .s1_cy      (s1_cy),
    .s1_area_p0 (s1_area_p0),
    .s1_area_p1 (s1_area_p1),
    .s2_valid   (s2_valid),
    .s2_ready   (s2_ready),
    .s2_px      (s2_px),
    .s2_py      (s2_py),
    .s2_last    (s2_last),
    .s2_m0      (s2_m0),
    .s2_m1      (s2_m1),
    .s2_m2      (s2_m2),
    .s2_m3      (s2_m3),
    .s2_area    (s2_area)
  );

  // coverage test and result register
  bbrt_cover #(
    .COORD_BITS (COORD_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_cover (
    .clk            (clk),
    .rst_n          (rst_n),
    .s2_valid       (s2_valid),
    .s2_ready       (s2_ready),
    .s2_px          (s2_px),
    .s2_py          (s2_py),
    .s2_last        (s2_last),
    .s2_m0          (s2_m0),
    .s2_m1          (s2_m1),
    .s2_m2          (s2_m2),
    .s2_m3          (s2_m3),
    .s2_area        (s2_area),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_covered    (out_covered),
    .out_last_pixel (out_last_pixel)
  );

endmodule
